[rtl/core/crc_pkg.sv]
// shared types and constants for the circle versus rectangle hit test core
package crc_pkg;

	localparam int unsigned FRAC_BITS_DEF = 16;

	localparam int unsigned ZSL_W  = 16;
	localparam int unsigned ADDR_W = 3;
	localparam int unsigned REM_W  = 33;
	localparam int unsigned VABS_W = 32;
	localparam int unsigned NUM_W  = 35;
	localparam int unsigned IN_W   = 288;
	localparam int unsigned OUT_W  = 8;

	localparam logic REG_ZERO_SPEED_LIMIT = 1'b0;

	localparam logic [ZSL_W-1:0] ZSL_RESET = 16'd1;

	typedef struct packed {
		logic [REM_W-1:0]  rem;
		logic [VABS_W-1:0] vabs;
		logic              neg;
		logic              sat;
	} div_in_t;

	typedef struct packed {
		logic valid;
		logic sweep;
		logic static_hit;
		logic still_x;
		logic still_y;
		logic inr_x;
		logic inr_y;
	} side_t;

endpackage

[rtl/core/crc_div_lane.sv]
// pipelined slab time divider, one quotient bit per stage, saturated signed result
module crc_div_lane #(
	parameter int unsigned FRAC_BITS = crc_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    en,
	input  crc_pkg::div_in_t        din,
	output logic signed [FRAC_BITS+2:0] t_out
);

	localparam int unsigned N  = FRAC_BITS + 1;
	localparam int unsigned QW = FRAC_BITS + 1;
	localparam int unsigned TW = FRAC_BITS + 3;

	logic [crc_pkg::REM_W-1:0]  rem_sd  [N];
	logic [crc_pkg::VABS_W-1:0] vabs_sd [N];
	logic [QW-1:0]              q_sd    [N];
	logic                       neg_sd  [N];
	logic                       sat_sd  [N];

	for (genvar j = 0; j < N; j++) begin : g_stage
		logic [crc_pkg::REM_W:0]    trial;
		logic                       ge;
		logic [crc_pkg::REM_W:0]    diff;
		logic [crc_pkg::VABS_W-1:0] vabs_in;
		logic [QW-1:0]              q_in;
		logic                       neg_in;
		logic                       sat_in;

		if (j == 0) begin : g_first
			assign trial   = {1'b0, din.rem};
			assign vabs_in = din.vabs;
			assign q_in    = '0;
			assign neg_in  = din.neg;
			assign sat_in  = din.sat;
		end else begin : g_next
			assign trial   = {rem_sd[j-1], 1'b0};
			assign vabs_in = vabs_sd[j-1];
			assign q_in    = q_sd[j-1];
			assign neg_in  = neg_sd[j-1];
			assign sat_in  = sat_sd[j-1];
		end

		assign ge   = trial >= {2'b00, vabs_in};
		assign diff = ge ? (trial - {2'b00, vabs_in}) : trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_sd[j]  <= diff[crc_pkg::REM_W-1:0];
				vabs_sd[j] <= vabs_in;
				q_sd[j]    <= {q_in[QW-2:0], ge};
				neg_sd[j]  <= neg_in;
				sat_sd[j]  <= sat_in;
			end
		end
	end

	logic [TW-1:0] mag;

	always_comb begin
		if (sat_sd[N-1]) begin
			mag = {{(TW-1){1'b0}}, 1'b1} << (FRAC_BITS + 1);
		end else begin
			mag = {2'b00, q_sd[N-1]};
		end
		t_out = neg_sd[N-1] ? -$signed(mag) : $signed(mag);
	end

endmodule

[rtl/core/circle_rect_collision_test_core.sv]
// circle versus rectangle static and swept hit test, top level
//
// channel   | direction | handshake               | payload
// s_*       | in        | s_tvalid / s_tready     | query geometry, sweep flag in tuser
// m_*       | out       | m_tvalid / m_tready     | hit bit
// apb       | in        | psel penable pwrite     | zero_speed_limit at address 0
//
// one query per cycle while the output is not stalled on m_tready
// the divider lanes produce one quotient bit per stage
// the whole pipe holds when the result waits on m_tready
// reset clears valid bits and sets zero_speed_limit to one
module circle_rect_collision_test_core #(
	parameter int unsigned FRAC_BITS = crc_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	// center_x, center_y, radius, vel_x, vel_y, rect_left, rect_right, rect_top, rect_bottom
	input  logic [crc_pkg::IN_W-1:0]    s_tdata,
	// sweep_enable
	input  logic [0:0]                  s_tuser,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// hit
	output logic [crc_pkg::OUT_W-1:0]   m_tdata,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [crc_pkg::ADDR_W-1:0]  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	localparam int unsigned DIV_N = FRAC_BITS + 1;
	localparam int unsigned TW    = FRAC_BITS + 3;
	localparam int unsigned NW    = crc_pkg::NUM_W;

	// config register
	logic [crc_pkg::ZSL_W-1:0] zsl_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zsl_q <= crc_pkg::ZSL_RESET;
		end else if (psel && penable && pwrite && pready
				&& paddr[2] == crc_pkg::REG_ZERO_SPEED_LIMIT) begin
			zsl_q <= pwdata[crc_pkg::ZSL_W-1:0];
		end
	end

	assign prdata = (paddr[2] == crc_pkg::REG_ZERO_SPEED_LIMIT)
		? {16'd0, zsl_q} : 32'd0;

	// pipe enable
	logic en;
	logic valid_s4;
	logic hit_s4;

	assign en       = !valid_s4 || m_tready;
	assign s_tready = en;
	assign m_tvalid = valid_s4;
	assign m_tdata  = {7'd0, hit_s4};

	// field unpack
	logic signed [31:0] cx, cy, vx, vy, rl, rr, rt, rb;
	logic        [30:0] rad;

	assign cx  = s_tdata[31:0];
	assign cy  = s_tdata[63:32];
	assign rad = s_tdata[94:64];
	assign vx  = s_tdata[126:95];
	assign vy  = s_tdata[158:127];
	assign rl  = s_tdata[190:159];
	assign rr  = s_tdata[222:191];
	assign rt  = s_tdata[254:223];
	assign rb  = s_tdata[286:255];

	// stage 1: slab numerators, axis distances, stationary flags
	logic signed [NW-1:0] nxl_c, nxh_c, nyl_c, nyh_c;
	logic        [32:0]   dx_c, dy_c;
	logic        [31:0]   vxa_c, vya_c;

	always_comb begin
		nxl_c = NW'(rl) - NW'($signed({1'b0, rad})) - NW'(cx);
		nxh_c = NW'(rr) + NW'($signed({1'b0, rad})) - NW'(cx);
		nyl_c = NW'(rt) - NW'($signed({1'b0, rad})) - NW'(cy);
		nyh_c = NW'(rb) + NW'($signed({1'b0, rad})) - NW'(cy);
		if (cx < rl) begin
			dx_c = 33'(34'(rl) - 34'(cx));
		end else if (cx > rr) begin
			dx_c = 33'(34'(cx) - 34'(rr));
		end else begin
			dx_c = '0;
		end
		if (cy < rt) begin
			dy_c = 33'(34'(rt) - 34'(cy));
		end else if (cy > rb) begin
			dy_c = 33'(34'(cy) - 34'(rb));
		end else begin
			dy_c = '0;
		end
		vxa_c = vx[31] ? 32'(-vx) : 32'(vx);
		vya_c = vy[31] ? 32'(-vy) : 32'(vy);
	end

	logic                 valid_s1;
	logic signed [NW-1:0] nxl_s1, nxh_s1, nyl_s1, nyh_s1;
	logic        [32:0]   dx_s1, dy_s1;
	logic        [30:0]   rad_s1;
	logic        [31:0]   vxa_s1, vya_s1;
	logic                 vxn_s1, vyn_s1, sweep_s1, still_x_s1, still_y_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nxl_s1     <= nxl_c;
			nxh_s1     <= nxh_c;
			nyl_s1     <= nyl_c;
			nyh_s1     <= nyh_c;
			dx_s1      <= dx_c;
			dy_s1      <= dy_c;
			rad_s1     <= rad;
			vxa_s1     <= vxa_c;
			vya_s1     <= vya_c;
			vxn_s1     <= vx[31];
			vyn_s1     <= vy[31];
			sweep_s1   <= s_tuser[0];
			still_x_s1 <= (vxa_c == '0) || (vxa_c < {16'd0, zsl_q});
			still_y_s1 <= (vya_c == '0) || (vya_c < {16'd0, zsl_q});
		end
	end

	// stage 2: divider setup, squares
	function automatic crc_pkg::div_in_t div_setup(logic signed [NW-1:0] num,
			logic [31:0] vabs, logic vneg);
		logic [NW-1:0]    anum;
		crc_pkg::div_in_t d;
		anum   = num[NW-1] ? NW'(-num) : NW'(num);
		d.rem  = anum[crc_pkg::REM_W-1:0];
		d.vabs = vabs;
		d.neg  = num[NW-1] ^ vneg;
		d.sat  = anum >= {2'b00, vabs, 1'b0};
		return d;
	endfunction

	logic             valid_s2;
	crc_pkg::div_in_t dxl_s2, dxh_s2, dyl_s2, dyh_s2;
	logic [61:0]      dx2_s2, dy2_s2, r2_s2;
	logic             far_s2, sweep_s2, still_x_s2, still_y_s2, inr_x_s2, inr_y_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dxl_s2     <= div_setup(nxl_s1, vxa_s1, vxn_s1);
			dxh_s2     <= div_setup(nxh_s1, vxa_s1, vxn_s1);
			dyl_s2     <= div_setup(nyl_s1, vya_s1, vyn_s1);
			dyh_s2     <= div_setup(nyh_s1, vya_s1, vyn_s1);
			dx2_s2     <= dx_s1[30:0] * dx_s1[30:0];
			dy2_s2     <= dy_s1[30:0] * dy_s1[30:0];
			r2_s2      <= rad_s1 * rad_s1;
			far_s2     <= (dx_s1 > {2'b00, rad_s1}) || (dy_s1 > {2'b00, rad_s1});
			sweep_s2   <= sweep_s1;
			still_x_s2 <= still_x_s1;
			still_y_s2 <= still_y_s1;
			inr_x_s2   <= (nxl_s1 <= 0) && (nxh_s1 >= 0);
			inr_y_s2   <= (nyl_s1 <= 0) && (nyh_s1 >= 0);
		end
	end

	// divider lanes
	logic signed [TW-1:0] txl, txh, tyl, tyh;

	crc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_xl (
		.clk(clk), .en(en), .din(dxl_s2), .t_out(txl));
	crc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_xh (
		.clk(clk), .en(en), .din(dxh_s2), .t_out(txh));
	crc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_yl (
		.clk(clk), .en(en), .din(dyl_s2), .t_out(tyl));
	crc_div_lane #(.FRAC_BITS(FRAC_BITS)) u_div_yh (
		.clk(clk), .en(en), .din(dyh_s2), .t_out(tyh));

	// sideband alongside the divider
	crc_pkg::side_t side_sd [DIV_N];
	crc_pkg::side_t side_c;
	logic [62:0]    d2_c;

	always_comb begin
		d2_c              = {1'b0, dx2_s2} + {1'b0, dy2_s2};
		side_c.valid      = valid_s2;
		side_c.sweep      = sweep_s2;
		side_c.static_hit = !far_s2 && (d2_c <= {1'b0, r2_s2});
		side_c.still_x    = still_x_s2;
		side_c.still_y    = still_y_s2;
		side_c.inr_x      = inr_x_s2;
		side_c.inr_y      = inr_y_s2;
	end

	for (genvar k = 0; k < DIV_N; k++) begin : g_side
		crc_pkg::side_t side_in;

		if (k == 0) begin : g_first
			assign side_in = side_c;
		end else begin : g_next
			assign side_in = side_sd[k-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_sd[k] <= '0;
			end else if (en) begin
				side_sd[k] <= side_in;
			end
		end
	end

	// stage 3: order the slab times per axis
	crc_pkg::side_t       side_s3;
	logic signed [TW-1:0] txl_s3, txh_s3, tyl_s3, tyh_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
		end else if (en) begin
			side_s3 <= side_sd[DIV_N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			txl_s3 <= (txl > txh) ? txh : txl;
			txh_s3 <= (txl > txh) ? txl : txh;
			tyl_s3 <= (tyl > tyh) ? tyh : tyl;
			tyh_s3 <= (tyl > tyh) ? tyl : tyh;
		end
	end

	// stage 4: clip to the frame and decide
	localparam logic signed [TW-1:0] T_ONE = TW'(1) << FRAC_BITS;

	logic signed [TW-1:0] tmin_a, tmin_b, tmax_a, tmax_b;
	logic                 axes_ok, sweep_hit;

	always_comb begin
		tmin_a = '0;
		tmax_a = T_ONE;
		if (!side_s3.still_x) begin
			tmin_a = (txl_s3 > tmin_a) ? txl_s3 : tmin_a;
			tmax_a = (txh_s3 < tmax_a) ? txh_s3 : tmax_a;
		end
		tmin_b = tmin_a;
		tmax_b = tmax_a;
		if (!side_s3.still_y) begin
			tmin_b = (tyl_s3 > tmin_b) ? tyl_s3 : tmin_b;
			tmax_b = (tyh_s3 < tmax_b) ? tyh_s3 : tmax_b;
		end
		axes_ok   = (!side_s3.still_x || side_s3.inr_x)
			&& (!side_s3.still_y || side_s3.inr_y);
		sweep_hit = axes_ok && !(tmax_b < tmin_b) && (tmin_b <= T_ONE) && (tmax_b >= 0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= side_s3.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s4 <= side_s3.sweep ? sweep_hit : side_s3.static_hit;
		end
	end

`ifndef SYNTHESIS
	a_ready_follows_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output stage");

	a_s3_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && side_s3.valid |=> m_tvalid)
		else $error("request lost between last stages");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(valid_s1) && $stable(valid_s2) && $stable(side_s3.valid))
		else $error("pipe moved while stalled");
`endif

endmodule
